// ===== rtl/core/pidru_pkg.sv =====
// Shared types, codes and saturation helpers of the wrapping-sensor PID core.
// No dependencies; imported by every module in rtl/core.
package pidru_pkg;

  localparam int unsigned SENSOR_BITS_DEF    = 16;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 16;

  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned CFG_W  = 32;

  localparam logic [15:0] WRAP_RST  = 16'd4096;
  localparam logic [30:0] LIMIT_RST = 31'd65536;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_PID    = 3'd1,
    OP_BANG   = 3'd2,
    OP_UNWRAP = 3'd3,
    OP_SETPT  = 3'd4,
    OP_ZERO   = 3'd5,
    OP_MAX    = 3'd6,
    OP_CLRINT = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    LS_OK   = 2'd0,
    LS_HIGH = 2'd1,
    LS_LOW  = 2'd2,
    LS_DEAD = 2'd3
  } ls_e;

  typedef enum logic [2:0] {
    CFG_GAIN_P = 3'd0,
    CFG_GAIN_I = 3'd1,
    CFG_GAIN_D = 3'd2,
    CFG_WRAP   = 3'd3,
    CFG_LIMIT  = 3'd4,
    CFG_DEAD   = 3'd5
  } cfg_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else r = s[63:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/pidru_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on pidru_pkg.
module pidru_mul import pidru_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/pidru_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on pidru_pkg.
module pidru_div import pidru_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic        [31:0] divisor_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);

  logic [6:0]  cnt_q;
  logic        run_q, done_q, neg_q;
  logic [63:0] q_q;
  logic [32:0] rem_q;
  logic [31:0] dvs_q;
  logic [32:0] rem_sh;
  logic [33:0] diff;

  assign rem_sh = {rem_q[31:0], q_q[63]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[63];
      q_q   <= dividend_i[63] ? 64'(-dividend_i) : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      if (!diff[33]) begin
        rem_q <= diff[32:0];
        q_q   <= {q_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        q_q   <= {q_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 64'(-$signed(q_q)) : $signed(q_q);

endmodule

// ===== rtl/core/pid_controller_with_rollover_unwrap_core.sv =====
// Top level of the PID core on a wrapping position sensor: sequencer and state.
// Depends on pidru_pkg, pidru_mul and pidru_div.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: sensor_raw, time_ms, new_target,
//                                           max_wraps; tuser: opcode
// m_axis    out  m_axis_tvalid/tready       tdata: drive_value, position, limit_state
// cfg       in   cfg_we_i                   cfg_addr_i, cfg_wdata_i
//
// Non-update opcodes run apply, position and error steps; bang-bang adds a clamp;
// a PID update adds integral, gain, clamp and, if time elapsed, a derivative divide.
// One shared multiplier serves position, integral and all gain products;
// the divider resolves one quotient bit per cycle.
// Reset loads the register defaults; no item is taken while a step is in work.
// The result register lets the next transfer in while a result waits.
module pid_controller_with_rollover_unwrap_core import pidru_pkg::*; #(
  parameter int unsigned SENSOR_BITS    = SENSOR_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  localparam int unsigned IN_W  = ((72 + SENSOR_BITS + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // sensor_raw, time_ms, new_target, max_wraps, zero fill
  input  logic [IN_W-1:0] s_axis_tdata,
  // opcode
  input  logic [2:0]      s_axis_tuser,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // drive_value, position, limit_state, zero fill
  output logic [71:0]     m_axis_tdata,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_addr_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned LR_W = (SENSOR_BITS > 16) ? SENSOR_BITS : 16;
  localparam int unsigned CW   = LR_W + 4;
  localparam int unsigned SB   = SENSOR_BITS;

  localparam logic [4:0] ST_IDLE  = 5'd0,  ST_APPLY = 5'd1,  ST_POS_M = 5'd2,
                         ST_POS_A = 5'd3,  ST_ERR   = 5'd4,  ST_I_M   = 5'd5,
                         ST_I_A   = 5'd6,  ST_P_M   = 5'd7,  ST_P_A   = 5'd8,
                         ST_IL_M  = 5'd9,  ST_IL_A  = 5'd10, ST_IH_M  = 5'd11,
                         ST_IH_A  = 5'd12, ST_IT_A  = 5'd13, ST_D_M   = 5'd14,
                         ST_D_A   = 5'd15, ST_D_W   = 5'd16, ST_CLAMP = 5'd17,
                         ST_OUT   = 5'd18;

  logic [4:0] state_q;

  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic [15:0]        wrap_q;
  logic [30:0]        limit_q, dead_q;

  logic [2:0]         op_q;
  logic [LR_W-1:0]    raw_q;
  logic [31:0]        now_q;
  logic signed [31:0] ntgt_q;
  logic [7:0]         mw_q;

  logic [LR_W-1:0]     last_raw_q;
  logic [15:0]         wc_q;
  logic signed [LR_W:0] zo_q;
  logic signed [31:0]  target_q;
  logic signed [63:0]  integ_q;
  logic signed [31:0]  prev_err_q;
  logic [31:0]         prev_time_q;
  logic signed [31:0]  held_q;

  logic [31:0]         dt_q;
  logic signed [63:0]  pos_q, t_q, ti_q, cval_q;
  logic signed [31:0]  err_q;
  logic signed [PROD_W-1:0] pl_q;
  logic [1:0]          ls_q;

  logic                m_valid_q;
  logic [31:0]         out_drive_q, out_pos_q;
  logic [1:0]          out_ls_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     div_start, div_done;
  logic signed [63:0]       div_q;

  logic                s_acc;
  logic [CW-1:0]       r10, l10, w1, w9;
  logic                now_low, now_high, was_low, was_high;
  logic signed [97:0]  full_i;
  logic signed [63:0]  clamp_v, clamp_abs, lim_s, dead_s;

  pidru_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pidru_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p[63:0]),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign div_start     = (state_q == ST_D_A);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_POS_M: begin
        mul_a = MUL_W'($signed(wc_q));
        mul_b = {17'd0, wrap_q};
      end
      ST_I_M: begin
        mul_a = {err_q[31], err_q};
        mul_b = {1'b0, dt_q};
      end
      ST_P_M: begin
        mul_a = {gain_p_q[31], gain_p_q};
        mul_b = {err_q[31], err_q};
      end
      ST_IL_M: begin
        mul_a = {gain_i_q[31], gain_i_q};
        mul_b = {1'b0, integ_q[31:0]};
      end
      ST_IH_M: begin
        mul_a = {gain_i_q[31], gain_i_q};
        mul_b = {integ_q[63], integ_q[63:32]};
      end
      ST_D_M: begin
        mul_a = {gain_d_q[31], gain_d_q};
        mul_b = {err_q[31], err_q} - {prev_err_q[31], prev_err_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign r10 = CW'({raw_q, 3'b000}) + CW'({raw_q, 1'b0});
  assign l10 = CW'({last_raw_q, 3'b000}) + CW'({last_raw_q, 1'b0});
  assign w1  = CW'(wrap_q);
  assign w9  = CW'({wrap_q, 3'b000}) + CW'(wrap_q);
  assign now_low  = r10 < w1;
  assign now_high = r10 > w9;
  assign was_low  = l10 < w1;
  assign was_high = l10 > w9;

  assign full_i = ($signed({{32{mul_p[PROD_W-1]}}, mul_p}) <<< 32)
                + $signed({{32{pl_q[PROD_W-1]}}, pl_q});

  assign clamp_v   = (op_q == OP_PID) ? t_q : cval_q;
  assign clamp_abs = clamp_v[63] ? -clamp_v : clamp_v;
  assign lim_s     = {33'd0, limit_q};
  assign dead_s    = {33'd0, dead_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      wrap_q      <= WRAP_RST;
      limit_q     <= LIMIT_RST;
      dead_q      <= '0;
      last_raw_q  <= LR_W'(WRAP_RST >> 1);
      wc_q        <= '0;
      zo_q        <= '0;
      target_q    <= '0;
      integ_q     <= '0;
      prev_err_q  <= '0;
      prev_time_q <= '0;
      held_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_GAIN_P: gain_p_q <= cfg_wdata_i;
          CFG_GAIN_I: gain_i_q <= cfg_wdata_i;
          CFG_GAIN_D: gain_d_q <= cfg_wdata_i;
          CFG_WRAP:   wrap_q   <= cfg_wdata_i[15:0];
          CFG_LIMIT:  limit_q  <= cfg_wdata_i[30:0];
          CFG_DEAD:   dead_q   <= cfg_wdata_i[30:0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready && state_q != ST_OUT) m_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            state_q <= ST_APPLY;
            ls_q    <= LS_OK;
          end
        end
        ST_APPLY: begin
          dt_q <= now_q - prev_time_q;
          case (op_q)
            OP_INIT: begin
              prev_time_q <= now_q;
              prev_err_q  <= sat32(64'(target_q) - $signed({{(64-LR_W){1'b0}}, raw_q}));
              integ_q     <= '0;
              wc_q        <= '0;
              last_raw_q  <= LR_W'(wrap_q >> 1);
              zo_q        <= '0;
            end
            OP_PID, OP_BANG, OP_UNWRAP: begin
              if (now_low && was_high) wc_q <= wc_q + 16'd1;
              if (now_high && was_low) wc_q <= wc_q - 16'd1;
              last_raw_q <= raw_q;
            end
            OP_SETPT: begin
              target_q   <= ntgt_q;
              integ_q    <= '0;
              prev_err_q <= sat32(64'(ntgt_q) - $signed({{(64-LR_W){1'b0}}, raw_q}));
            end
            OP_ZERO: begin
              zo_q <= -$signed({1'b0, last_raw_q});
              wc_q <= '0;
            end
            OP_MAX: begin
              zo_q <= -$signed({1'b0, last_raw_q});
              wc_q <= {8'd0, mw_q};
            end
            default: integ_q <= '0;
          endcase
          state_q <= ST_POS_M;
        end
        ST_POS_M: state_q <= ST_POS_A;
        ST_POS_A: begin
          pos_q <= $signed(mul_p[63:0]) + $signed({{(64-LR_W){1'b0}}, last_raw_q})
                 + $signed({{(63-LR_W){zo_q[LR_W]}}, zo_q});
          state_q <= ST_ERR;
        end
        ST_ERR: begin
          err_q <= sat32(64'(target_q) - pos_q);
          if (op_q == OP_BANG) begin
            prev_err_q <= sat32(64'(target_q) - pos_q);
            cval_q  <= 64'(sat32(64'(target_q) - pos_q)) <<< GAIN_FRAC_BITS;
            state_q <= ST_CLAMP;
          end else if (op_q == OP_PID) begin
            state_q <= ST_I_M;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_I_M:  state_q <= ST_I_A;
        ST_I_A: begin
          integ_q <= sat_add64(integ_q, mul_p[63:0]);
          state_q <= ST_P_M;
        end
        ST_P_M:  state_q <= ST_P_A;
        ST_P_A: begin
          t_q     <= mul_p[63:0];
          state_q <= ST_IL_M;
        end
        ST_IL_M: state_q <= ST_IL_A;
        ST_IL_A: begin
          pl_q    <= mul_p;
          state_q <= ST_IH_M;
        end
        ST_IH_M: state_q <= ST_IH_A;
        ST_IH_A: begin
          if (full_i > $signed({35'd0, {63{1'b1}}})) ti_q <= {1'b0, {63{1'b1}}};
          else if (full_i < $signed({{35{1'b1}}, 63'd0})) ti_q <= {1'b1, 63'd0};
          else ti_q <= full_i[63:0];
          state_q <= ST_IT_A;
        end
        ST_IT_A: begin
          t_q     <= sat_add64(t_q, ti_q);
          state_q <= (dt_q != 32'd0) ? ST_D_M : ST_CLAMP;
        end
        ST_D_M:  state_q <= ST_D_A;
        ST_D_A:  state_q <= ST_D_W;
        ST_D_W: begin
          if (div_done) begin
            t_q     <= sat_add64(t_q, div_q);
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          if (op_q == OP_PID) begin
            prev_err_q  <= err_q;
            prev_time_q <= now_q;
          end
          if (clamp_v > lim_s) begin
            held_q <= {1'b0, limit_q};
            ls_q   <= LS_HIGH;
          end else if (clamp_v < -lim_s) begin
            held_q <= -$signed({1'b0, limit_q});
            ls_q   <= LS_LOW;
          end else if (clamp_abs < dead_s) begin
            held_q <= '0;
            ls_q   <= LS_DEAD;
            if (op_q == OP_PID) integ_q <= '0;
          end else begin
            held_q <= clamp_v[31:0];
            ls_q   <= LS_OK;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q   <= s_axis_tuser;
      raw_q  <= LR_W'(s_axis_tdata[SB-1:0]);
      now_q  <= s_axis_tdata[SB+31:SB];
      ntgt_q <= s_axis_tdata[SB+63:SB+32];
      mw_q   <= s_axis_tdata[SB+71:SB+64];
    end
    if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
      out_drive_q <= held_q;
      out_pos_q   <= sat32(pos_q);
      out_ls_q    <= ls_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, out_ls_q, out_pos_q, out_drive_q};

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken during a step");

  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_ls_q == LS_DEAD) |-> (out_drive_q == 32'd0))
    else $error("dead zone result with nonzero drive");

  a_high_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_ls_q == LS_HIGH) |-> (out_drive_q == {1'b0, limit_q}))
    else $error("high clamp not at limit");

  a_div_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_D_M) |-> (dt_q != 32'd0))
    else $error("derivative divide with zero elapsed time");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_D_W))
    else $error("divider finished outside its wait");

endmodule
